// ===== sv/tpt_pkg.sv =====
// Package for the trapezoid position tracker core.
// Holds the controller/datapath command and status types and fixed constants.
// Depends on nothing.
package tpt_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_TRAVEL_SPEED = 3'd0;
    localparam logic [2:0] REG_ACCEL_LIMIT  = 3'd1;
    localparam logic [2:0] REG_TRACK_GAIN   = 3'd2;
    localparam logic [2:0] REG_ERPM_SCALE   = 3'd3;
    localparam logic [2:0] REG_MAX_ERPM     = 3'd4;
    localparam logic [2:0] REG_TOLERANCE    = 3'd5;

    // Register reset values.
    localparam logic [9:0]  RST_TRAVEL_SPEED = 10'd50;
    localparam logic [13:0] RST_ACCEL_LIMIT  = 14'd80;
    localparam logic [15:0] RST_TRACK_GAIN   = 16'd672;
    localparam logic [15:0] RST_ERPM_SCALE   = 16'd100;
    localparam logic [14:0] RST_MAX_ERPM     = 15'd20000;
    localparam logic [6:0]  RST_TOLERANCE    = 7'd1;

    // Shared divider: dividend and divisor widths.
    localparam int DIV_W = 36;
    localparam int DVS_W = 16;

    // Payload widths of the stream ports.
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_SEED_DIV,
        OP_SEED,
        OP_SQUARE,
        OP_STOP_DIV,
        OP_STOP,
        OP_SDIV_DIV,
        OP_SDIV,
        OP_STEP_DIV,
        OP_STEP,
        OP_SPEED,
        OP_POS_DIV,
        OP_POS,
        OP_MUL,
        OP_REQ,
        OP_OUT
    } tpt_op_t;

    typedef struct packed {
        tpt_op_t op;
    } tpt_cmd_t;

    typedef struct packed {
        logic func;
        logic fb_ok;
        logic at_rest;
        logic div_done;
        logic div_busy;
    } tpt_status_t;

endpackage

// ===== sv/tpt_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on tpt_pkg for the operand widths.
module tpt_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tpt_pkg::DIV_W-1:0]     dividend,
    input  logic [tpt_pkg::DVS_W-1:0]     divisor,
    output logic [tpt_pkg::DIV_W-1:0]     quotient,
    output logic                          done,
    output logic                          busy
);
    import tpt_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                rem_reg <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
    assign busy     = busy_reg;

endmodule

// ===== sv/tpt_datapath.sv =====
// Datapath of the tracker: configuration registers, ramp state, multipliers,
// the serial divider, the tick-rate reciprocal and the result register.
// Depends on tpt_pkg, tpt_divider.
module tpt_datapath #(
    parameter int TICK_HZ = 100
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tpt_pkg::tpt_cmd_t              cmd,
    output tpt_pkg::tpt_status_t           status,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_wdata,
    input  logic [tpt_pkg::S_DATA_W-1:0]   in_data,
    input  logic [tpt_pkg::S_USER_W-1:0]   in_user,
    output logic [tpt_pkg::M_DATA_W-1:0]   out_data
);
    import tpt_pkg::*;

    localparam logic [26:0]      SPD_LIM  = {1'b0, 10'd1023, 16'd0};

    // Division by the tick rate is a multiplication by a rounded-up reciprocal.
    // With the shift at the operand width plus ceil(log2(TICK_HZ)) the product
    // gives the truncated quotient exactly for every operand below 2^RCP_X_W.
    localparam int          RCP_X_W = 30;
    localparam int          RCP_SH  = RCP_X_W + $clog2(TICK_HZ);
    localparam longint      RCP_M   = ((longint'(1) << RCP_SH) + longint'(TICK_HZ) - 1)
                                      / longint'(TICK_HZ);
    localparam logic [31:0] RCP_MUL = 32'(RCP_M);

    // Configuration.
    logic [9:0]  travel_reg;
    logic [13:0] accel_reg;
    logic [15:0] gain_reg;
    logic [15:0] scale_reg;
    logic [14:0] maxs_reg;
    logic [6:0]  tol_reg;

    // Latched item.
    logic               func_reg;
    logic               fb_reg;
    logic signed [15:0] target_reg;
    logic signed [15:0] meas_reg;
    logic signed [16:0] mspd_reg;

    // Ramp state.
    logic signed [31:0] pos_reg;
    logic signed [26:0] spd_reg;
    logic [1:0]         dir_reg;
    logic signed [15:0] lerr_reg;

    // Working registers.
    logic signed [32:0] rem_reg;
    logic [32:0]        rem_abs_reg;
    logic [51:0]        sq_reg;
    logic [34:0]        stop_reg;
    logic [25:0]        sdiv_reg;
    logic [29:0]        step_reg;
    logic signed [43:0] prod1_reg;
    logic signed [49:0] prod2_reg;
    logic signed [15:0] req_reg;
    logic               run_reg;
    logic               idle_reg;
    logic [M_DATA_W-1:0] out_reg;

    // Divider.
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_q;
    logic             div_done;
    logic             div_busy;

    // Tick-rate reciprocal.
    logic                  rcp_start;
    logic [RCP_X_W-1:0]    rcp_x;
    logic [RCP_X_W+31:0]   rcp_prod_reg;
    logic                  rcp_done_reg;
    logic [RCP_X_W-1:0]    rcp_q;

    // Combinational terms.
    logic signed [16:0] err_diff;
    logic signed [15:0] err_c;
    logic [16:0]        err_abs;
    logic [26:0]        spd_abs_c;
    logic [16:0]        mspd_abs;
    logic [15:0]        scale_nz;
    logic [13:0]        accel_nz;
    logic signed [31:0] target_q;
    logic signed [32:0] rem_c;
    logic [22:0]        tol_q;
    logic [25:0]        travel_q;
    logic [35:0]        guard;
    logic               rem_pos;
    logic               rem_neg;
    logic               spd_pos;
    logic               spd_neg;
    logic               zero_des;
    logic signed [31:0] des32;
    logic signed [31:0] spd32;
    logic signed [31:0] up32;
    logic signed [31:0] dn32;
    logic signed [31:0] spd_new;
    logic [25:0]        seed_mag;
    logic signed [33:0] spq34;
    logic signed [33:0] nxt34;
    logic signed [33:0] tq34;
    logic signed [32:0] track;
    logic signed [50:0] req_sum;
    logic signed [50:0] req_rnd;
    logic signed [34:0] req_quo;
    logic signed [34:0] maxs35;
    logic signed [15:0] req_c;
    logic signed [32:0] rpos_rnd;
    logic signed [27:0] rspd_rnd;

    assign err_diff = 17'(target_reg) - 17'(meas_reg);
    always_comb begin
        if (err_diff > 17'sd32767)
            err_c = 16'sh7fff;
        else if (err_diff < -17'sd32768)
            err_c = 16'sh8000;
        else
            err_c = err_diff[15:0];
    end
    assign err_abs   = err_c[15] ? 17'(-17'(err_c)) : 17'(err_c);
    assign spd_abs_c = spd_reg[26] ? 27'(-spd_reg) : 27'(spd_reg);
    assign mspd_abs  = mspd_reg[16] ? 17'(-mspd_reg) : 17'(mspd_reg);
    assign scale_nz  = (scale_reg != '0) ? scale_reg : 16'd1;
    assign accel_nz  = (accel_reg != '0) ? accel_reg : 14'd1;
    assign target_q  = {target_reg, 16'd0};
    assign rem_c     = 33'(target_q) - 33'(pos_reg);
    assign tol_q     = {tol_reg, 16'd0};
    assign travel_q  = {travel_reg, 16'd0};

    assign status.func     = func_reg;
    assign status.fb_ok    = fb_reg;
    assign status.at_rest  = (err_abs <= 17'(tol_reg)) && (pos_reg == target_q)
                             && (spd_reg == '0);
    assign status.div_done = div_done || rcp_done_reg;
    assign status.div_busy = div_busy;

    // Divider and reciprocal operand selection.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        rcp_start    = 1'b0;
        rcp_x        = '0;
        case (cmd.op)
            OP_SEED_DIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({mspd_abs, 16'd0});
                div_divisor  = scale_nz;
            end
            OP_STOP_DIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(sq_reg[51:17]);
                div_divisor  = DVS_W'(accel_nz);
            end
            OP_SDIV_DIV: begin
                rcp_start = 1'b1;
                rcp_x     = RCP_X_W'(spd_abs_c);
            end
            OP_STEP_DIV: begin
                rcp_start = 1'b1;
                rcp_x     = {accel_reg, 16'd0};
            end
            OP_POS_DIV: begin
                rcp_start = 1'b1;
                rcp_x     = RCP_X_W'(spd_abs_c);
            end
            default: ;
        endcase
    end

    tpt_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done),
        .busy     (div_busy)
    );

    assign rcp_q = RCP_X_W'(rcp_prod_reg >> RCP_SH);

    // Ramp speed update.
    assign rem_pos  = !rem_reg[32] && (rem_reg != '0);
    assign rem_neg  = rem_reg[32];
    assign spd_pos  = !spd_reg[26] && (spd_reg != '0);
    assign spd_neg  = spd_reg[26];
    assign guard    = 36'(stop_reg) + 36'(sdiv_reg) + 36'(tol_q);
    assign zero_des = (rem_abs_reg <= 33'(tol_q)) || (rem_pos && spd_neg)
                      || (rem_neg && spd_pos) || (36'(rem_abs_reg) <= guard);
    assign spd32    = 32'(spd_reg);
    assign up32     = spd32 + $signed({2'b00, step_reg});
    assign dn32     = spd32 - $signed({2'b00, step_reg});
    always_comb begin
        if (zero_des)
            des32 = '0;
        else if (rem_pos)
            des32 = $signed({6'd0, travel_q});
        else
            des32 = -$signed({6'd0, travel_q});
        if (spd32 < des32)
            spd_new = (up32 > des32) ? des32 : up32;
        else if (spd32 > des32)
            spd_new = (dn32 < des32) ? des32 : dn32;
        else
            spd_new = spd32;
    end

    // Seed clamp and position step.
    assign seed_mag = (div_q[32:0] > 33'(travel_q)) ? travel_q : div_q[25:0];
    assign spq34    = spd_reg[26] ? -$signed({8'd0, rcp_q[25:0]})
                                  : $signed({8'd0, rcp_q[25:0]});
    assign nxt34    = 34'(pos_reg) + spq34;
    assign tq34     = 34'(target_q);

    // Speed request.
    assign track   = 33'(pos_reg) - 33'($signed({meas_reg, 16'd0}));
    assign req_sum = 51'(prod1_reg) + 51'(prod2_reg);
    assign req_rnd = req_sum[50] ? req_sum + 51'sd65535 : req_sum;
    assign req_quo = 35'(req_rnd >>> 16);
    assign maxs35  = $signed({20'd0, maxs_reg});
    always_comb begin
        if (req_quo > maxs35)
            req_c = maxs35[15:0];
        else if (req_quo < -maxs35)
            req_c = 16'(-maxs35);
        else
            req_c = req_quo[15:0];
    end

    assign rpos_rnd = pos_reg[31] ? 33'(pos_reg) + 33'sd65535 : 33'(pos_reg);
    assign rspd_rnd = spd_reg[26] ? 28'(spd_reg) + 28'sd65535 : 28'(spd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            travel_reg   <= RST_TRAVEL_SPEED;
            accel_reg    <= RST_ACCEL_LIMIT;
            gain_reg     <= RST_TRACK_GAIN;
            scale_reg    <= RST_ERPM_SCALE;
            maxs_reg     <= RST_MAX_ERPM;
            tol_reg      <= RST_TOLERANCE;
            pos_reg      <= '0;
            spd_reg      <= '0;
            dir_reg      <= '0;
            lerr_reg     <= '0;
            func_reg     <= 1'b0;
            fb_reg       <= 1'b0;
            run_reg      <= 1'b0;
            idle_reg     <= 1'b0;
            req_reg      <= '0;
            rcp_done_reg <= 1'b0;
        end else begin
            rcp_done_reg <= rcp_start;
            if (rcp_start)
                rcp_prod_reg <= rcp_x * RCP_MUL;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TRAVEL_SPEED: travel_reg <= cfg_wdata[9:0];
                    REG_ACCEL_LIMIT:  accel_reg  <= cfg_wdata[13:0];
                    REG_TRACK_GAIN:   gain_reg   <= cfg_wdata;
                    REG_ERPM_SCALE:   scale_reg  <= cfg_wdata;
                    REG_MAX_ERPM:     maxs_reg   <= cfg_wdata[14:0];
                    REG_TOLERANCE:    tol_reg    <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD: begin
                    func_reg   <= in_user[0];
                    fb_reg     <= in_user[1];
                    target_reg <= in_data[15:0];
                    meas_reg   <= in_data[31:16];
                    mspd_reg   <= in_data[48:32];
                    req_reg    <= '0;
                    run_reg    <= 1'b0;
                    idle_reg   <= !in_user[0] && !in_user[1];
                end
                OP_CHECK: begin
                    lerr_reg    <= err_c;
                    rem_reg     <= rem_c;
                    rem_abs_reg <= rem_c[32] ? 33'(-rem_c) : 33'(rem_c);
                end
                OP_SEED: begin
                    pos_reg <= {meas_reg, 16'd0};
                    spd_reg <= mspd_reg[16] ? -$signed({1'b0, seed_mag})
                                            : $signed({1'b0, seed_mag});
                end
                OP_SQUARE: sq_reg   <= spd_abs_c[25:0] * spd_abs_c[25:0];
                OP_STOP:   stop_reg <= div_q[34:0];
                OP_SDIV:   sdiv_reg <= rcp_q[25:0];
                OP_STEP:   step_reg <= rcp_q[29:0];
                OP_SPEED:  spd_reg  <= spd_new[26:0];
                OP_POS: begin
                    if ((rem_abs_reg <= 33'(tol_q)) && (spd_reg == '0)) begin
                        pos_reg <= target_q;
                    end else if ((rem_pos && (nxt34 >= tq34))
                                 || (rem_neg && (nxt34 <= tq34))) begin
                        pos_reg <= target_q;
                        spd_reg <= '0;
                    end else begin
                        pos_reg <= nxt34[31:0];
                    end
                end
                OP_MUL: begin
                    prod1_reg <= 44'(spd_reg) * 44'($signed({1'b0, scale_reg}));
                    prod2_reg <= 50'(track) * 50'($signed({1'b0, gain_reg}));
                end
                OP_REQ: begin
                    req_reg <= req_c;
                    run_reg <= 1'b1;
                    if (req_c > 16'sd0)
                        dir_reg <= 2'd1;
                    else if (req_c < 16'sd0)
                        dir_reg <= 2'd2;
                end
                OP_OUT: begin
                    out_reg <= {4'd0, idle_reg, lerr_reg,
                                {{4{rspd_rnd[27]}}, rspd_rnd[27:16]},
                                rpos_rnd[31:16], dir_reg, run_reg, req_reg};
                end
                default: ;
            endcase
        end
    end

    assign out_data = out_reg;

    // The ramp speed never leaves the largest cruise speed the register allows.
    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        spd_abs_c <= SPD_LIM)
        else $error("ramp speed beyond cruise bound");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

endmodule

// ===== sv/tpt_ctrl.sv =====
// Controller of the tracker: sequences the datapath operations for one item
// and owns the stream handshakes. Depends on tpt_pkg.
module tpt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  tpt_pkg::tpt_status_t  status,
    output tpt_pkg::tpt_cmd_t     cmd
);
    import tpt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEED_GO,
        ST_SEED_WAIT,
        ST_CHECK,
        ST_SQUARE,
        ST_STOP_GO,
        ST_STOP_WAIT,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_SPEED,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_MUL,
        ST_REQ,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;
    logic   in_wait;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_wait  = (state_reg == ST_SEED_WAIT) || (state_reg == ST_STOP_WAIT)
                      || (state_reg == ST_SDIV_WAIT) || (state_reg == ST_STEP_WAIT)
                      || (state_reg == ST_POS_WAIT);

    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) cmd.op = OP_LOAD;
            ST_SEED_GO:   cmd.op = OP_SEED_DIV;
            ST_SEED_WAIT: if (status.div_done) cmd.op = OP_SEED;
            ST_CHECK:     cmd.op = OP_CHECK;
            ST_SQUARE:    cmd.op = OP_SQUARE;
            ST_STOP_GO:   cmd.op = OP_STOP_DIV;
            ST_STOP_WAIT: if (status.div_done) cmd.op = OP_STOP;
            ST_SDIV_GO:   cmd.op = OP_SDIV_DIV;
            ST_SDIV_WAIT: if (status.div_done) cmd.op = OP_SDIV;
            ST_STEP_GO:   cmd.op = OP_STEP_DIV;
            ST_STEP_WAIT: if (status.div_done) cmd.op = OP_STEP;
            ST_SPEED:     cmd.op = OP_SPEED;
            ST_POS_GO:    cmd.op = OP_POS_DIV;
            ST_POS_WAIT:  if (status.div_done) cmd.op = OP_POS;
            ST_MUL:       cmd.op = OP_MUL;
            ST_REQ:       cmd.op = OP_REQ;
            ST_OUT:       if (out_free) cmd.op = OP_OUT;
            default:      cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_OUT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:     if (s_tvalid) state_reg <= ST_DISPATCH;
                ST_DISPATCH: begin
                    if (status.func)
                        state_reg <= ST_SEED_GO;
                    else if (!status.fb_ok)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_CHECK;
                end
                ST_SEED_GO:   state_reg <= ST_SEED_WAIT;
                ST_SEED_WAIT: if (status.div_done) state_reg <= ST_OUT;
                ST_CHECK:     state_reg <= status.at_rest ? ST_OUT : ST_SQUARE;
                ST_SQUARE:    state_reg <= ST_STOP_GO;
                ST_STOP_GO:   state_reg <= ST_STOP_WAIT;
                ST_STOP_WAIT: if (status.div_done) state_reg <= ST_SDIV_GO;
                ST_SDIV_GO:   state_reg <= ST_SDIV_WAIT;
                ST_SDIV_WAIT: if (status.div_done) state_reg <= ST_STEP_GO;
                ST_STEP_GO:   state_reg <= ST_STEP_WAIT;
                ST_STEP_WAIT: if (status.div_done) state_reg <= ST_SPEED;
                ST_SPEED:     state_reg <= ST_POS_GO;
                ST_POS_GO:    state_reg <= ST_POS_WAIT;
                ST_POS_WAIT:  if (status.div_done) state_reg <= ST_MUL;
                ST_MUL:       state_reg <= ST_REQ;
                ST_REQ:       state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    // While waiting for a quotient the divider must actually be running.
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_wait && !status.div_done) |-> status.div_busy)
        else $error("waiting on an idle divider");

    // A new result beat is only raised from the output state.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result beat raised outside the output state");

endmodule

// ===== sv/trapezoid_position_tracker_core.sv =====
// Trapezoid position tracker core. Each input beat is either a control tick
// (tuser bit 0 low) or a trajectory reset (tuser bit 0 high), and each one
// produces exactly one result beat. A reset makes one 36-step pass of the
// serial divider for the speed scale. A tick with invalid feedback goes from
// dispatch straight to the output load, and one that finds the ramp at rest on
// the target goes through the check to the output load. A tick that advances
// the ramp takes one divider pass for the braking distance, three reciprocal
// multiplications by the tick rate (speed over the tick rate, acceleration
// step, position step), the square, the speed and position updates, the two
// request products and the output load. The next beat is accepted in the
// cycle after the output load. One item is in work at a time; a new beat is
// accepted while the previous result still waits in the output register, and
// the output load stalls while a waiting result is not taken. Configuration
// writes are meant for idle periods.
module trapezoid_position_tracker_core #(
    parameter int TICK_HZ = 100
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // target_pos[15:0], measured_pos[31:16], measured_speed[48:32], zero pad
    input  logic [tpt_pkg::S_DATA_W-1:0]  s_tdata,
    // func[0], feedback_ok[1]
    input  logic [tpt_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // speed_request[15:0], run_flag[16], drive_dir[18:17], ramp_pos[34:19],
    // ramp_speed[50:35], pos_error[66:51], went_idle[67], zero pad
    output logic [tpt_pkg::M_DATA_W-1:0]  m_tdata
);
    import tpt_pkg::*;

    tpt_cmd_t    cmd;
    tpt_status_t status;

    // The controller walks the operation sequence and owns both handshakes.
    tpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, ramp state, arithmetic and result.
    tpt_datapath #(
        .TICK_HZ (TICK_HZ)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .out_data  (m_tdata)
    );

endmodule

// ===== dv/trapezoid_position_tracker_core_tb.sv =====
// Self-checking testbench for trapezoid_position_tracker_core.
// Needs tpt_pkg and the core; a behavioral tracker model predicts each result beat.
`timescale 1ns / 100ps

module trapezoid_position_tracker_core_tb;
    import tpt_pkg::*;

    localparam longint Q16 = 65536;
    localparam longint TICK_RATE = 100;
    // The settle time is well above the slowest tick, so it is safe.
    localparam int SETTLE_CYCLES = 250;

    typedef struct {
        bit          func;
        shortint     target;
        shortint     measured;
        int          mspeed;
        bit          fb_ok;
    } tick_item_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    trapezoid_position_tracker_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Tracker state mirrored by the predictor.
    longint cfg_regs [6];
    longint ramp_pos_q;
    longint ramp_spd_q;
    int     held_dir;
    longint last_err;

    // Expected result beats, packed as on m_tdata.
    logic [M_DATA_W-1:0] expected_beats [$];
    int mismatches;
    int tx_idle_pct;
    int rx_idle_pct;
    string field_names [7] = '{"speed_request", "run_flag", "drive_dir", "ramp_pos",
                               "ramp_speed", "pos_error", "went_idle"};

    function automatic longint abs_l(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint clamp_l(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic void write_reg_model(int idx, longint value);
        int widths [6] = '{10, 14, 16, 16, 15, 7};
        cfg_regs[idx] = value & ((longint'(1) << widths[idx]) - 1);
    endfunction

    // Move the ramp one tick toward the target.
    function automatic void advance_ramp(longint tgt_q);
        longint travel_q, accel, tol_q, remaining, rem_abs, spd_abs;
        longint divisor, stop_dist, guard, desired, step, next_pos;
        logic [31:0] low_word;
        travel_q  = cfg_regs[REG_TRAVEL_SPEED] * Q16;
        accel     = cfg_regs[REG_ACCEL_LIMIT];
        tol_q     = cfg_regs[REG_TOLERANCE] * Q16;
        remaining = tgt_q - ramp_pos_q;
        rem_abs   = abs_l(remaining);
        spd_abs   = abs_l(ramp_spd_q);
        divisor   = 2 * (accel > 0 ? accel : 1) * Q16;
        stop_dist = (spd_abs * spd_abs) / divisor;
        guard     = stop_dist + spd_abs / TICK_RATE + tol_q;
        step      = (accel * Q16) / TICK_RATE;

        if (rem_abs <= tol_q)
            desired = 0;
        else if ((remaining > 0 && ramp_spd_q < 0) || (remaining < 0 && ramp_spd_q > 0) ||
                 rem_abs <= guard)
            desired = 0;
        else
            desired = remaining > 0 ? travel_q : -travel_q;

        if (ramp_spd_q < desired) begin
            ramp_spd_q += step;
            if (ramp_spd_q > desired) ramp_spd_q = desired;
        end else if (ramp_spd_q > desired) begin
            ramp_spd_q -= step;
            if (ramp_spd_q < desired) ramp_spd_q = desired;
        end

        next_pos = ramp_pos_q + ramp_spd_q / TICK_RATE;
        if (rem_abs <= tol_q && ramp_spd_q == 0) begin
            next_pos = tgt_q;
        end else if ((remaining > 0 && next_pos >= tgt_q) ||
                     (remaining < 0 && next_pos <= tgt_q)) begin
            next_pos = tgt_q;
            ramp_spd_q = 0;
        end
        // The ramp position wraps to 32 bits.
        low_word = next_pos[31:0];
        ramp_pos_q = longint'($signed(low_word));
    endfunction

    // Predict the result beat of one accepted item and update the state.
    function automatic logic [M_DATA_W-1:0] track_position(tick_item_t it);
        longint request, scale, travel_q, tgt_q, err, track, maxs, rp, rs;
        logic run, idle;
        logic [M_DATA_W-1:0] beat;
        request = 0;
        run = 1'b0;
        idle = 1'b0;
        if (it.func) begin
            travel_q = cfg_regs[REG_TRAVEL_SPEED] * Q16;
            scale = cfg_regs[REG_ERPM_SCALE] != 0 ? cfg_regs[REG_ERPM_SCALE] : 1;
            ramp_pos_q = longint'(it.measured) * Q16;
            ramp_spd_q = clamp_l((longint'(it.mspeed) * Q16) / scale, -travel_q, travel_q);
        end else if (!it.fb_ok) begin
            idle = 1'b1;
        end else begin
            tgt_q = longint'(it.target) * Q16;
            err = clamp_l(longint'(it.target) - longint'(it.measured), -32768, 32767);
            last_err = err;
            if (!(abs_l(err) <= cfg_regs[REG_TOLERANCE] && ramp_pos_q == tgt_q &&
                  ramp_spd_q == 0)) begin
                maxs = cfg_regs[REG_MAX_ERPM];
                advance_ramp(tgt_q);
                track = ramp_pos_q - longint'(it.measured) * Q16;
                request = (ramp_spd_q * cfg_regs[REG_ERPM_SCALE] +
                           track * cfg_regs[REG_TRACK_GAIN]) / Q16;
                request = clamp_l(request, -maxs, maxs);
                if (request > 0) held_dir = 1;
                else if (request < 0) held_dir = 2;
                run = 1'b1;
            end
        end
        rp = ramp_pos_q / Q16;
        rs = ramp_spd_q / Q16;
        beat = '0;
        beat[15:0]  = request[15:0];
        beat[16]    = run;
        beat[18:17] = held_dir[1:0];
        beat[34:19] = rp[15:0];
        beat[50:35] = rs[15:0];
        beat[66:51] = last_err[15:0];
        beat[67]    = idle;
        return beat;
    endfunction

    // Result checker: every accepted beat is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                logic [M_DATA_W-1:0] exp_beat;
                logic [15:0] exp_f [7];
                logic [15:0] got_f [7];
                exp_beat = expected_beats.pop_front();
                exp_f = '{exp_beat[15:0], 16'(exp_beat[16]), 16'(exp_beat[18:17]),
                          exp_beat[34:19], exp_beat[50:35], exp_beat[66:51],
                          16'(exp_beat[67])};
                got_f = '{m_tdata[15:0], 16'(m_tdata[16]), 16'(m_tdata[18:17]),
                          m_tdata[34:19], m_tdata[50:35], m_tdata[66:51],
                          16'(m_tdata[67])};
                foreach (exp_f[i]) begin
                    if (exp_f[i] !== got_f[i]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t %s: expected %h, got %h", $realtime,
                                     field_names[i], exp_f[i], got_f[i]);
                    end
                end
            end
        end
    end

    // The receiver stalls at random, once per cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Send one beat; the prediction is made at the edge where it is accepted.
    task automatic send_item(tick_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.mspeed[16:0], it.measured, it.target};
        s_tuser  <= {it.fb_ok, it.func};
        do @(posedge aclk); while (!s_tready);
        expected_beats.push_back(track_position(it));
    endtask

    task automatic send_fields(bit func, int target, int measured, int mspeed, bit fb_ok);
        tick_item_t it;
        it.func = func;
        it.target = shortint'(target);
        it.measured = shortint'(measured);
        // Only the 17 bits that travel on the bus count, as a signed value.
        it.mspeed = int'($signed(mspeed[16:0]));
        it.fb_ok = fb_ok;
        send_item(it);
    endtask

    // Hold the sender until every expected result has come, then let the core settle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_beats.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        write_reg_model(idx, value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_regs(int tr, int ac, int gn, int sc, int mx, int tl);
        drain_results();
        write_reg(REG_TRAVEL_SPEED, tr);
        write_reg(REG_ACCEL_LIMIT, ac);
        write_reg(REG_TRACK_GAIN, gn);
        write_reg(REG_ERPM_SCALE, sc);
        write_reg(REG_MAX_ERPM, mx);
        write_reg(REG_TOLERANCE, tl);
    endtask

    // Directed beats: field extremes, both functions and each special case.
    task automatic test_directed();
        send_fields(1'b0, 0, 0, 0, 1'b1);              // at rest on target after reset
        send_fields(1'b0, 100, 0, 0, 1'b0);            // invalid feedback goes idle
        send_fields(1'b1, 0, 32767, 65535, 1'b1);      // reset, top extremes
        send_fields(1'b0, -32768, 32767, 0, 1'b1);     // largest error, saturated
        send_fields(1'b1, 0, -32768, -65536, 1'b0);    // reset, bottom extremes
        send_fields(1'b0, 32767, -32768, -1, 1'b1);
        send_fields(1'b0, 5, 5, 0, 1'b0);
        send_fields(1'b1, 0, 40, 0, 1'b1);
        send_fields(1'b0, 40, 40, 0, 1'b1);            // ramp at rest on the target
        send_fields(1'b0, 41, 40, 0, 1'b1);            // within tolerance, snaps
        send_fields(1'b0, 20, 30, 0, 1'b1);
        send_fields(1'b0, 20, 25, 0, 1'b1);
        // Largest settings, then zero accel and zero speed scale.
        write_all_regs(1023, 16383, 65535, 65535, 32767, 127);
        send_fields(1'b1, 0, 0, 65535, 1'b1);
        send_fields(1'b0, 32767, -32768, 0, 1'b1);
        send_fields(1'b0, -32768, 32767, 0, 1'b1);
        write_all_regs(1, 0, 0, 0, 0, 0);
        send_fields(1'b1, 0, 10, -700, 1'b1);          // reset divides by one
        send_fields(1'b0, 500, 10, 0, 1'b1);           // zero accel, zero step
        send_fields(1'b0, -500, 10, 0, 1'b1);
        write_all_regs(50, 80, 672, 100, 20000, 1);
        send_fields(1'b0, 7, 7, 0, 1'b1);
        send_fields(1'b0, 7, 7, 0, 1'b1);
    endtask

    task automatic randomize_regs();
        case ($urandom_range(5))
            0: write_all_regs(1023, 16383, 65535, 65535, 32767, 127);
            1: write_all_regs(1, 1, 0, 1, 0, 0);
            default: write_all_regs($urandom_range(1000, 1), $urandom_range(10000, 1),
                                    $urandom_range(2000), $urandom_range(300, 1),
                                    $urandom_range(32767), $urandom_range(10));
        endcase
    endtask

    // Random part: mostly a trajectory reset followed by ticks whose measured
    // position trails the ramp, so the ramp runs through every phase; the rest
    // are beats with every field random.
    task automatic test_random(int count);
        int sent;
        int base;
        int len;
        int meas;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                send_fields($urandom_range(1), $urandom, $urandom, $urandom, $urandom_range(1));
                sent++;
            end else begin
                base = $urandom_range(20000) - 10000;
                send_fields(1'b1, 0, base, $urandom_range(4000) - 2000, 1'b1);
                base = ($urandom_range(3) == 0) ? $urandom_range(65535) - 32768
                                                : base + $urandom_range(60) - 30;
                base = int'(clamp_l(base, -32768, 32767));
                len = $urandom_range(40, 5);
                for (int i = 0; i < len; i++) begin
                    meas = int'(clamp_l(ramp_pos_q / Q16 + $urandom_range(4) - 2,
                                        -32768, 32767));
                    if ($urandom_range(3) == 0) meas = base;
                    send_fields(1'b0, base, meas, $urandom, $urandom_range(19) != 0);
                end
                sent += len + 1;
            end
        end
    endtask

    task automatic test_phase(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < 4; i++) begin
            randomize_regs();
            test_random(100);
        end
    endtask

    initial begin
        mismatches  = 0;
        tx_idle_pct = 25;
        rx_idle_pct = 48;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TRAVEL_SPEED;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        for (int i = 0; i < 6; i++) write_reg_model(i, 0);
        write_reg_model(REG_TRAVEL_SPEED, RST_TRAVEL_SPEED);
        write_reg_model(REG_ACCEL_LIMIT, RST_ACCEL_LIMIT);
        write_reg_model(REG_TRACK_GAIN, RST_TRACK_GAIN);
        write_reg_model(REG_ERPM_SCALE, RST_ERPM_SCALE);
        write_reg_model(REG_MAX_ERPM, RST_MAX_ERPM);
        write_reg_model(REG_TOLERANCE, RST_TOLERANCE);
        ramp_pos_q = 0;
        ramp_spd_q = 0;
        held_dir   = 0;
        last_err   = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_phase(25, 48);
        test_phase(48, 25);
        test_phase(0, 0);
        drain_results();

        if (mismatches == 0)
            $display("[trapezoid_position_tracker_core] OK");
        else
            $display("[trapezoid_position_tracker_core] ERROR");
        $finish;
    end

    // Watchdog: the slowest correct run is well under a tenth of this.
    initial begin
        #200_000_000;
        $display("[trapezoid_position_tracker_core] ERROR");
        $finish;
    end

endmodule

// ===== trapezoid_position_tracker_core.f =====
sv/tpt_pkg.sv
sv/tpt_divider.sv
sv/tpt_datapath.sv
sv/tpt_ctrl.sv
sv/trapezoid_position_tracker_core.sv
dv/trapezoid_position_tracker_core_tb.sv
